@@ hdl/rtsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Render target slot allocator - shared definitions
// Status and opcode codes, register indexes and the bitmap fit helpers.
// ----------------------------------------------------------------------------
package rtsa_pkg;

   localparam int REG_WORDS = 8;           // words in the output register map
   localparam int DEF_NUM_TILE_BUFS = 8;
   localparam int DEF_WORDS_PER_BUFFER = 8;

   // Result status codes
   localparam logic [1:0] ST_OUT_REG   = 2'd0;
   localparam logic [1:0] ST_TILE_BUF  = 2'd1;
   localparam logic [1:0] ST_NO_BUFFER = 2'd2;
   localparam logic [1:0] ST_TOO_LARGE = 2'd3;

   // Request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Configuration register indexes
   localparam logic CSR_MAX_OUTPUT_REGS = 1'b0;
   localparam logic CSR_EVEN_ALIGN_WIDE = 1'b1;

   typedef struct packed {
      logic       found;
      logic [2:0] offset;
   } fit_type;

   // Run of size words starting at start, bits above 15 dropped
   function automatic logic [15:0] run_mask(input logic [2:0] start, input logic [4:0] size);
      logic [31:0] m;
      m = ((32'd1 << size) - 32'd1) << start;
      return m[15:0];
   endfunction

   // Lowest free run of size words inside limit words; candidates are checked
   // independently and the lowest wins.
   function automatic fit_type find_fit(input logic [7:0] map, input logic [3:0] limit,
                                        input logic [4:0] size, input logic even);
      fit_type     r;
      logic [15:0] m;
      logic        step2;
      r.found  = 1'b0;
      r.offset = 3'd0;
      step2    = even && (size == 5'd2 || size == 5'd4);
      if (size == 5'd0) begin
         r.found = 1'b1;
      end else begin
         for (int i = REG_WORDS - 1; i >= 0; i--) begin
            m = run_mask(3'(i), size);
            if ((6'(i) + 6'(size) <= 6'(limit)) && !(step2 && i[0])
                && ((16'(map) & m) == 16'd0)) begin
               r.found  = 1'b1;
               r.offset = 3'(i);
            end
         end
      end
      return r;
   endfunction

   // Round up to a power of two, minimum 1, capped at 8
   function automatic logic [3:0] round_pow2(input logic [3:0] v);
      logic [3:0] r;
      if (v <= 4'd1)      r = 4'd1;
      else if (v <= 4'd2) r = 4'd2;
      else if (v <= 4'd4) r = 4'd4;
      else                r = 4'd8;
      return r;
   endfunction

endpackage

@@ hdl/render_target_slot_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Render target slot allocator core
// First-fit placement of render targets in output register and tile buffer
// word bitmaps.
// ----------------------------------------------------------------------------
// One transaction at a time. A transaction is taken in, then checked against
// the output register map; an item that lands in the output registers, a
// clear, or an oversized target finishes there. When the target does not fit
// in the register map, the tile buffer bitmaps are read from a one-port-read,
// one-port-write memory, one buffer per cycle while the output register is
// free, scanned in order from the lowest open buffer.
// The result sits in an output register; the next transaction is taken while
// it waits, but is not finished until the output register is free. The tile
// buffer memory needs no clearing: only buffers below the open count are ever
// read, and opening a buffer writes its whole bitmap.
// ----------------------------------------------------------------------------
module render_target_slot_allocator_core #(
   parameter int NUM_TILE_BUFS    = rtsa_pkg::DEF_NUM_TILE_BUFS,
   parameter int WORDS_PER_BUFFER = rtsa_pkg::DEF_WORDS_PER_BUFFER
) (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [3:0] csr_data,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [5:0] req_accum_bytes,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_word_offset,
   output logic [2:0] rsp_buffer_index,
   output logic [5:0] rsp_intermediate_bytes,
   output logic [7:0] rsp_target_index,
   output logic [3:0] rsp_regs_in_use,
   output logic [3:0] rsp_regs_rounded,
   output logic [3:0] rsp_buffers_in_use
);
   import rtsa_pkg::*;

   // Only the first min(WORDS_PER_BUFFER, REG_WORDS) words of a buffer are
   // ever reachable, since the buffer limit never exceeds the register limit.
   localparam int BUF_W = (WORDS_PER_BUFFER < REG_WORDS) ? WORDS_PER_BUFFER : REG_WORDS;
   localparam int AW    = (NUM_TILE_BUFS > 1) ? $clog2(NUM_TILE_BUFS) : 1;
   localparam int CNT_W = $clog2(NUM_TILE_BUFS + 1);
   localparam logic [CNT_W-1:0] TB_CNT = CNT_W'(NUM_TILE_BUFS);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a transaction
   localparam logic [1:0] S_EVAL = 2'd1;  // register map check, clear, size check
   localparam logic [1:0] S_SCAN = 2'd2;  // one tile buffer bitmap per cycle while the output is free

   // ---------------------------------------------------------------- state
   logic [1:0]        state_ff, state_in;
   logic              op_ff, op_in;
   logic [5:0]        bytes_ff, bytes_in;
   logic [4:0]        size_ff, size_in;
   logic [AW-1:0]     scan_ff, scan_in;

   logic [REG_WORDS-1:0] reg_map_ff, reg_map_in;
   logic [CNT_W-1:0]  open_cnt_ff, open_cnt_in;
   logic [3:0]        hwu_ff, hwu_in;          // highest word used plus one
   logic [7:0]        tgt_cnt_ff, tgt_cnt_in;

   logic [3:0]        max_regs_ff;
   logic              even_ff;

   // tile buffer bitmaps
   logic [BUF_W-1:0]  buf_mem [NUM_TILE_BUFS];
   logic [BUF_W-1:0]  rd_data_ff;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BUF_W-1:0]  wr_data;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [2:0]        rsp_offset_ff, rsp_offset_in;
   logic [2:0]        rsp_buf_ff, rsp_buf_in;
   logic [5:0]        rsp_inter_ff, rsp_inter_in;
   logic [7:0]        rsp_index_ff, rsp_index_in;
   logic [3:0]        rsp_in_use_ff, rsp_in_use_in;
   logic [3:0]        rsp_rounded_ff, rsp_rounded_in;
   logic [3:0]        rsp_bufs_ff, rsp_bufs_in;

   // ---------------------------------------------------------------- limits
   logic [3:0] reg_limit;
   logic [3:0] buf_limit;

   always_comb begin
      if (max_regs_ff == 4'd0)                 reg_limit = 4'd1;
      else if (max_regs_ff > 4'(REG_WORDS))    reg_limit = 4'(REG_WORDS);
      else                                     reg_limit = max_regs_ff;
      if (reg_limit < 4'(BUF_W)) buf_limit = reg_limit;
      else                       buf_limit = 4'(BUF_W);
   end

   logic out_free;
   logic req_take;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   fit_type reg_fit;
   fit_type buf_fit;
   assign reg_fit = find_fit(8'(reg_map_ff), reg_limit, size_ff, even_ff);
   assign buf_fit = find_fit(8'(rd_data_ff), buf_limit, size_ff, even_ff);

   logic [15:0] reg_mask;
   logic [15:0] buf_mask;
   logic [15:0] new_mask;
   assign reg_mask = run_mask(reg_fit.offset, size_ff);
   assign buf_mask = run_mask(buf_fit.offset, size_ff);
   assign new_mask = run_mask(3'd0, size_ff);

   // ---------------------------------------------------------------- sequencer
   logic          finish;
   logic          res_ok;      // placement made: bump counters
   logic          try_new;     // no existing space: open a new buffer
   logic [1:0]    res_status;
   logic [2:0]    res_offset;
   logic [AW-1:0] res_buf;
   logic [7:0]    res_index;
   logic [5:0]    end_word;
   logic [AW+2:0] buf_wide;
   logic [CNT_W+3:0] cnt_wide;
   logic [CNT_W-1:0] scan_next;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      bytes_in    = bytes_ff;
      size_in     = size_ff;
      scan_in     = scan_ff;
      reg_map_in  = reg_map_ff;
      open_cnt_in = open_cnt_ff;
      hwu_in      = hwu_ff;
      tgt_cnt_in  = tgt_cnt_ff;
      rd_en       = 1'b0;
      rd_addr     = scan_ff;
      wr_en       = 1'b0;
      wr_addr     = scan_ff;
      wr_data     = rd_data_ff | buf_mask[BUF_W-1:0];
      finish      = 1'b0;
      res_ok      = 1'b0;
      try_new     = 1'b0;
      res_status  = ST_OUT_REG;
      res_offset  = 3'd0;
      res_buf     = '0;
      res_index   = tgt_cnt_ff;
      scan_next   = CNT_W'(scan_ff) + CNT_W'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in    = req_opcode;
               bytes_in = req_accum_bytes;
               size_in  = 5'((7'(req_accum_bytes) + 7'd3) >> 2);
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (out_free) begin
               if (op_ff == OP_CLEAR) begin
                  finish      = 1'b1;
                  reg_map_in  = '0;
                  open_cnt_in = '0;
                  hwu_in      = 4'd0;
                  tgt_cnt_in  = 8'd0;
                  res_index   = 8'd0;
                  state_in    = S_IDLE;
               end else if (size_ff > 5'(reg_limit)) begin
                  finish     = 1'b1;
                  res_status = ST_TOO_LARGE;
                  state_in   = S_IDLE;
               end else if (reg_fit.found) begin
                  finish     = 1'b1;
                  res_ok     = 1'b1;
                  res_offset = reg_fit.offset;
                  reg_map_in = reg_map_ff | reg_mask[REG_WORDS-1:0];
                  state_in   = S_IDLE;
               end else if (open_cnt_ff != '0) begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  scan_in  = '0;
                  state_in = S_SCAN;
               end else begin
                  try_new = 1'b1;
               end
            end
         end
         S_SCAN: begin
            // rd_data_ff holds buffer scan_ff; it stays put while we wait
            if (out_free) begin
               if (buf_fit.found) begin
                  finish     = 1'b1;
                  res_ok     = 1'b1;
                  res_status = ST_TILE_BUF;
                  res_offset = buf_fit.offset;
                  res_buf    = scan_ff;
                  wr_en      = 1'b1;
                  wr_addr    = scan_ff;
                  wr_data    = rd_data_ff | buf_mask[BUF_W-1:0];
                  state_in   = S_IDLE;
               end else if (scan_next < open_cnt_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = scan_next[AW-1:0];
                  scan_in = scan_next[AW-1:0];
               end else begin
                  try_new = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // open a fresh tile buffer, or report why not
      if (try_new) begin
         finish   = 1'b1;
         state_in = S_IDLE;
         if (open_cnt_ff >= TB_CNT) begin
            res_status = ST_NO_BUFFER;
         end else if (size_ff > 5'(buf_limit)) begin
            res_status = ST_TOO_LARGE;
         end else begin
            res_ok      = 1'b1;
            res_status  = ST_TILE_BUF;
            res_buf     = open_cnt_ff[AW-1:0];
            wr_en       = 1'b1;
            wr_addr     = open_cnt_ff[AW-1:0];
            wr_data     = new_mask[BUF_W-1:0];
            open_cnt_in = open_cnt_ff + CNT_W'(1);
         end
      end

      end_word = 6'(res_offset) + 6'(size_ff);
      if (res_ok) begin
         if (size_ff != 5'd0 && end_word > 6'(hwu_ff)) hwu_in = end_word[3:0];
         tgt_cnt_in = tgt_cnt_ff + 8'd1;
      end

      buf_wide = (AW + 3)'(res_buf);
      cnt_wide = (CNT_W + 4)'(open_cnt_in);

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_buf_in     = rsp_buf_ff;
      rsp_inter_in   = rsp_inter_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_in_use_in  = rsp_in_use_ff;
      rsp_rounded_in = rsp_rounded_ff;
      rsp_bufs_in    = rsp_bufs_ff;
      if (finish) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = res_status;
         rsp_offset_in  = res_ok ? res_offset : 3'd0;
         rsp_buf_in     = res_ok ? buf_wide[2:0] : 3'd0;
         rsp_inter_in   = res_ok ? bytes_ff : 6'd0;
         rsp_index_in   = res_index;
         rsp_in_use_in  = hwu_in;
         rsp_rounded_in = round_pow2(hwu_in);
         rsp_bufs_in    = cnt_wide[3:0];
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         reg_map_ff   <= '0;
         open_cnt_ff  <= '0;
         hwu_ff       <= 4'd0;
         tgt_cnt_ff   <= 8'd0;
         max_regs_ff  <= 4'(REG_WORDS);
         even_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reg_map_ff   <= reg_map_in;
         open_cnt_ff  <= open_cnt_in;
         hwu_ff       <= hwu_in;
         tgt_cnt_ff   <= tgt_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MAX_OUTPUT_REGS: max_regs_ff <= csr_data;
               CSR_EVEN_ALIGN_WIDE: even_ff     <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      bytes_ff       <= bytes_in;
      size_ff        <= size_in;
      scan_ff        <= scan_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_buf_ff     <= rsp_buf_in;
      rsp_inter_ff   <= rsp_inter_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_in_use_ff  <= rsp_in_use_in;
      rsp_rounded_ff <= rsp_rounded_in;
      rsp_bufs_ff    <= rsp_bufs_in;
   end

   // tile buffer bitmap memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) buf_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= buf_mem[rd_addr];
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_word_offset        = rsp_offset_ff;
   assign rsp_buffer_index       = rsp_buf_ff;
   assign rsp_intermediate_bytes = rsp_inter_ff;
   assign rsp_target_index       = rsp_index_ff;
   assign rsp_regs_in_use        = rsp_in_use_ff;
   assign rsp_regs_rounded       = rsp_rounded_ff;
   assign rsp_buffers_in_use     = rsp_bufs_ff;

   // ---------------------------------------------------------------- checks
   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_cnt_ff <= TB_CNT)
      else $error("open tile buffer count above buffer total");

   a_hwu_bound: assert property (@(posedge clock) disable iff (reset)
      hwu_ff <= 4'(REG_WORDS))
      else $error("highest word used beyond register map");

   a_write_opened: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (CNT_W'($past(wr_addr)) < open_cnt_ff))
      else $error("bitmap written for a buffer that is not open");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_EVAL || $past(state_ff) == S_SCAN))
      else $error("result raised outside evaluation or scan");

endmodule
